### rtl/core/euler_step_particle_on_circle_assert.svh
// Assertion macros used by the checker of the Euler step block.
`ifndef EULER_STEP_PARTICLE_ON_CIRCLE_ASSERT_SVH
`define EULER_STEP_PARTICLE_ON_CIRCLE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ESPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ESPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/core/espc_pkg.sv
// Package with types, constants and arithmetic helpers of the Euler step block.
`default_nettype none
package espc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int MAG_BITS  = 2 * WORD_BITS - FRAC_BITS;
    localparam int UREG_BITS = 31;
    localparam int NUM_REGS  = 8;
    localparam int ADDR_BITS = 5;
    localparam int STEP_BITS = 4;
    localparam int CNT_BITS  = 6;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [UREG_BITS-1:0]        ureg_t;
    typedef logic [STEP_BITS-1:0]        step_t;

    localparam logic [2:0] REG_STEP_SIZE = 3'd0;
    localparam logic [2:0] REG_MASS      = 3'd1;
    localparam logic [2:0] REG_GRAVITY   = 3'd2;
    localparam logic [2:0] REG_RADIUS    = 3'd3;
    localparam logic [2:0] REG_START_X   = 3'd4;
    localparam logic [2:0] REG_START_Y   = 3'd5;
    localparam logic [2:0] REG_START_VX  = 3'd6;
    localparam logic [2:0] REG_START_VY  = 3'd7;

    localparam ureg_t RST_STEP_SIZE = 31'd655;
    localparam ureg_t RST_MASS      = 31'd65536;
    localparam ureg_t RST_GRAVITY   = 31'd642908;
    localparam ureg_t RST_RADIUS    = 31'd65536;
    localparam word_t RST_START_X   = 32'sd11380;
    localparam word_t RST_START_Y   = 32'sd64540;
    localparam word_t RST_START_VX  = 32'sd6454;
    localparam word_t RST_START_VY  = -32'sd1138;

    // Sequence of multiply steps; three of them feed the divider.
    localparam step_t STEP_GY   = 4'd0;
    localparam step_t STEP_UU   = 4'd1;
    localparam step_t STEP_VV   = 4'd2;
    localparam step_t STEP_MS   = 4'd3;
    localparam step_t STEP_HU   = 4'd4;
    localparam step_t STEP_HV   = 4'd5;
    localparam step_t STEP_NX   = 4'd6;
    localparam step_t STEP_HDX  = 4'd7;
    localparam step_t STEP_NY   = 4'd8;
    localparam step_t STEP_MG   = 4'd9;
    localparam step_t STEP_HDY  = 4'd10;

    localparam logic [CNT_BITS-1:0] DIV_LAST_CNT = CNT_BITS'(MAG_BITS - 1);

    typedef struct packed {
        ureg_t step_size;
        ureg_t mass;
        ureg_t gravity;
        ureg_t radius;
        word_t start_x;
        word_t start_y;
        word_t start_vx;
        word_t start_vy;
    } cfg_t;

    typedef struct packed {
        logic  load;
        logic  mul_start;
        logic  mul_post;
        logic  div_iter;
        logic  div_post;
        logic  out_load;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } status_t;

    function automatic logic is_div_step(input step_t step);
        return (step == STEP_MS) || (step == STEP_NX) || (step == STEP_NY);
    endfunction

    function automatic word_t sat_pack(input logic neg, input logic [MAG_BITS-1:0] mag);
        logic [MAG_BITS-1:0] lim;
        logic [MAG_BITS-1:0] m;
        lim = (MAG_BITS'(1) << (WORD_BITS - 1)) - MAG_BITS'(!neg);
        m = (mag > lim) ? lim : mag;
        return neg ? word_t'(-m[WORD_BITS-1:0]) : word_t'(m[WORD_BITS-1:0]);
    endfunction

    function automatic word_t sat_word(input logic signed [WORD_BITS:0] s);
        if (s[WORD_BITS] != s[WORD_BITS-1])
        begin
            return s[WORD_BITS] ? word_t'({1'b1, {(WORD_BITS-1){1'b0}}})
                                : word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
        end
        return word_t'(s[WORD_BITS-1:0]);
    endfunction

    function automatic word_t sat_add(input word_t a, input word_t b);
        return sat_word({a[WORD_BITS-1], a} + {b[WORD_BITS-1], b});
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        return sat_word({a[WORD_BITS-1], a} - {b[WORD_BITS-1], b});
    endfunction

endpackage
`default_nettype wire

### rtl/core/espc_if.sv
// Handshake interfaces for the input and result channels.
`default_nettype none
interface espc_in_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface espc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] raw_force;
    logic [30:0]        contact_force;
    logic               detached;
    modport source (output valid, output pos_x, output pos_y, output vel_x, output vel_y,
                    output raw_force, output contact_force, output detached, input ready);
    modport sink (input valid, input pos_x, input pos_y, input vel_x, input vel_y,
                  input raw_force, input contact_force, input detached, output ready);
endinterface
`default_nettype wire

### rtl/core/euler_step_particle_on_circle.sv
// Top level of the explicit Euler step of a particle on a circle.
//
//   channel   direction  handshake              word
//   in_ch     in         valid / ready          restart
//   out_ch    out        valid / ready          pos, vel, forces, detached
//   apb       in         psel/penable/pready    8 registers at 4*i
//
// A restart word loads the start state, then the finish state loads the output.
// A step word runs eleven shared-multiplier steps, each a multiply and a post state,
// and three one-bit-per-cycle divider passes of 48 iterations and a post state.
// The block takes one word at a time; a new word is accepted while the last
// result still waits in the output register. Reset loads the default settings
// and the default start state. A stalled output holds the block before its result.
`default_nettype none
module euler_step_particle_on_circle
    import espc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    espc_in_if.sink                   in_ch,
    espc_out_if.source                out_ch
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    espc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    espc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_restart (in_ch.restart),
        .in_ready   (in_ch.ready),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .status     (status),
        .cmd        (cmd)
    );

    espc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .status        (status),
        .pos_x         (out_ch.pos_x),
        .pos_y         (out_ch.pos_y),
        .vel_x         (out_ch.vel_x),
        .vel_y         (out_ch.vel_y),
        .raw_force     (out_ch.raw_force),
        .contact_force (out_ch.contact_force),
        .detached      (out_ch.detached)
    );

endmodule
`default_nettype wire

### rtl/core/espc_regs.sv
// APB register file holding the step, physics and start-state settings.
`default_nettype none
module espc_regs
    import espc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output cfg_t                      cfg
);

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size <= RST_STEP_SIZE;
            cfg_reg.mass      <= RST_MASS;
            cfg_reg.gravity   <= RST_GRAVITY;
            cfg_reg.radius    <= RST_RADIUS;
            cfg_reg.start_x   <= RST_START_X;
            cfg_reg.start_y   <= RST_START_Y;
            cfg_reg.start_vx  <= RST_START_VX;
            cfg_reg.start_vy  <= RST_START_VY;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_STEP_SIZE: cfg_reg.step_size <= pwdata[UREG_BITS-1:0];
                REG_MASS:      cfg_reg.mass      <= pwdata[UREG_BITS-1:0];
                REG_GRAVITY:   cfg_reg.gravity   <= pwdata[UREG_BITS-1:0];
                REG_RADIUS:    cfg_reg.radius    <= pwdata[UREG_BITS-1:0];
                REG_START_X:   cfg_reg.start_x   <= pwdata;
                REG_START_Y:   cfg_reg.start_y   <= pwdata;
                REG_START_VX:  cfg_reg.start_vx  <= pwdata;
                REG_START_VY:  cfg_reg.start_vy  <= pwdata;
                default:       cfg_reg.start_vy  <= cfg_reg.start_vy;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_STEP_SIZE: prdata = {1'b0, cfg_reg.step_size};
            REG_MASS:      prdata = {1'b0, cfg_reg.mass};
            REG_GRAVITY:   prdata = {1'b0, cfg_reg.gravity};
            REG_RADIUS:    prdata = {1'b0, cfg_reg.radius};
            REG_START_X:   prdata = cfg_reg.start_x;
            REG_START_Y:   prdata = cfg_reg.start_y;
            REG_START_VX:  prdata = cfg_reg.start_vx;
            REG_START_VY:  prdata = cfg_reg.start_vy;
            default:       prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/espc_dp.sv
// Datapath with the state, one shared multiplier and a bit-serial divider.
`default_nettype none
module espc_dp
    import espc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire cmd_t  cmd,
    output status_t    status,
    output word_t      pos_x,
    output word_t      pos_y,
    output word_t      vel_x,
    output word_t      vel_y,
    output word_t      raw_force,
    output ureg_t      contact_force,
    output logic       detached
);

    word_t x_reg, y_reg, u_reg, v_reg;
    word_t s_reg, q_reg, nx_reg, ny_reg, nvx_reg;
    ureg_t n_reg;
    logic [2*WORD_BITS-1:0] prod_reg;
    logic                   mneg_reg;
    logic [MAG_BITS-1:0]    den_reg, quo_reg;
    logic [WORD_BITS-1:0]   rem_reg;
    logic                   dneg_reg, dzero_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    word_t out_x_reg, out_y_reg, out_vx_reg, out_vy_reg, out_q_reg;
    ureg_t out_n_reg;

    word_t                op_a, op_b, mulres, divres;
    logic [WORD_BITS-1:0] mag_a, mag_b, div_mag;
    logic [WORD_BITS-1:0] rem_sh;
    logic                 rem_ge;

    always_comb
    begin
        unique case (cmd.step)
            STEP_GY:  begin op_a = {1'b0, cfg.gravity};   op_b = y_reg; end
            STEP_UU:  begin op_a = u_reg;                 op_b = u_reg; end
            STEP_VV:  begin op_a = v_reg;                 op_b = v_reg; end
            STEP_MS:  begin op_a = {1'b0, cfg.mass};      op_b = s_reg; end
            STEP_HU:  begin op_a = {1'b0, cfg.step_size}; op_b = u_reg; end
            STEP_HV:  begin op_a = {1'b0, cfg.step_size}; op_b = v_reg; end
            STEP_NX:  begin op_a = {1'b0, n_reg};         op_b = x_reg; end
            STEP_NY:  begin op_a = {1'b0, n_reg};         op_b = y_reg; end
            STEP_MG:  begin op_a = {1'b0, cfg.mass};      op_b = {1'b0, cfg.gravity}; end
            default:  begin op_a = {1'b0, cfg.step_size}; op_b = s_reg; end
        endcase
    end

    assign mag_a   = op_a[WORD_BITS-1] ? (WORD_BITS'(0) - op_a) : op_a;
    assign mag_b   = op_b[WORD_BITS-1] ? (WORD_BITS'(0) - op_b) : op_b;
    assign mulres  = sat_pack(mneg_reg, prod_reg[2*WORD_BITS-1:FRAC_BITS]);
    assign div_mag = mulres[WORD_BITS-1] ? (WORD_BITS'(0) - mulres) : mulres;

    assign rem_sh = {rem_reg[WORD_BITS-2:0], den_reg[MAG_BITS-1]};
    assign rem_ge = rem_sh >= {1'b0, cfg.radius};

    always_comb
    begin
        if (cfg.radius == '0)
        begin
            divres = dzero_reg ? '0 : sat_pack(dneg_reg, '1);
        end
        else
        begin
            divres = sat_pack(dneg_reg, quo_reg);
        end
    end

    assign status.div_last = (cnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            prod_reg <= mag_a * mag_b;
            mneg_reg <= op_a[WORD_BITS-1] ^ op_b[WORD_BITS-1];
        end
        if (cmd.mul_post && is_div_step(cmd.step))
        begin
            den_reg   <= {div_mag, {FRAC_BITS{1'b0}}};
            rem_reg   <= '0;
            quo_reg   <= '0;
            dneg_reg  <= mulres[WORD_BITS-1];
            dzero_reg <= (mulres == '0);
        end
        else if (cmd.div_iter)
        begin
            den_reg <= {den_reg[MAG_BITS-2:0], 1'b0};
            rem_reg <= rem_ge ? (rem_sh - {1'b0, cfg.radius}) : rem_sh;
            quo_reg <= {quo_reg[MAG_BITS-2:0], rem_ge};
        end
        if (cmd.out_load)
        begin
            out_x_reg  <= x_reg;
            out_y_reg  <= y_reg;
            out_vx_reg <= u_reg;
            out_vy_reg <= v_reg;
            out_q_reg  <= q_reg;
            out_n_reg  <= n_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.mul_post && is_div_step(cmd.step))
        begin
            cnt_reg <= DIV_LAST_CNT;
        end
        else if (cmd.div_iter && (cnt_reg != '0))
        begin
            cnt_reg <= cnt_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= RST_START_X;
            y_reg <= RST_START_Y;
            u_reg <= RST_START_VX;
            v_reg <= RST_START_VY;
            q_reg <= '0;
            n_reg <= '0;
        end
        else if (cmd.load)
        begin
            x_reg <= cfg.start_x;
            y_reg <= cfg.start_y;
            u_reg <= cfg.start_vx;
            v_reg <= cfg.start_vy;
            q_reg <= '0;
            n_reg <= '0;
        end
        else if (cmd.mul_post)
        begin
            unique case (cmd.step)
                STEP_GY:  s_reg   <= mulres;
                STEP_UU:  s_reg   <= sat_sub(s_reg, mulres);
                STEP_VV:  s_reg   <= sat_sub(s_reg, mulres);
                STEP_HU:  nx_reg  <= sat_add(x_reg, mulres);
                STEP_HV:  ny_reg  <= sat_add(y_reg, mulres);
                STEP_HDX: nvx_reg <= sat_add(u_reg, mulres);
                STEP_MG:  s_reg   <= sat_sub(s_reg, mulres);
                STEP_HDY:
                begin
                    x_reg <= nx_reg;
                    y_reg <= ny_reg;
                    u_reg <= nvx_reg;
                    v_reg <= sat_add(v_reg, mulres);
                end
                default:  s_reg   <= s_reg;
            endcase
        end
        else if (cmd.div_post)
        begin
            if (cmd.step == STEP_MS)
            begin
                q_reg <= divres;
                n_reg <= divres[WORD_BITS-1] ? '0 : divres[UREG_BITS-1:0];
            end
            else
            begin
                s_reg <= divres;
            end
        end
    end

    assign pos_x         = out_x_reg;
    assign pos_y         = out_y_reg;
    assign vel_x         = out_vx_reg;
    assign vel_y         = out_vy_reg;
    assign raw_force     = out_q_reg;
    assign contact_force = out_n_reg;
    assign detached      = out_q_reg[WORD_BITS-1];

endmodule
`default_nettype wire

### rtl/core/espc_ctrl.sv
// Controller that sequences the multiply and divide steps of one Euler step.
`default_nettype none
module espc_ctrl
    import espc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    in_restart,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_POST  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DPOST = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [2:0] state_reg, state_next;
    step_t      step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.step       = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    step_next = STEP_GY;
                    if (in_restart)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul_start = 1'b1;
                state_next    = ST_POST;
            end
            ST_POST:
            begin
                cmd.mul_post = 1'b1;
                if (is_div_step(step_reg))
                begin
                    state_next = ST_DIV;
                end
                else if (step_reg == STEP_HDY)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    step_next  = step_reg + STEP_BITS'(1);
                    state_next = ST_MUL;
                end
            end
            ST_DIV:
            begin
                cmd.div_iter = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DPOST;
                end
            end
            ST_DPOST:
            begin
                cmd.div_post = 1'b1;
                step_next    = step_reg + STEP_BITS'(1);
                state_next   = ST_MUL;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_GY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/espc_checker.sv
// Port-level checker of the Euler step block and its bind.
`default_nettype none
`include "euler_step_particle_on_circle_assert.svh"
module espc_checker
    import espc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] pos_x,
    input wire logic [31:0] raw_force,
    input wire logic [30:0] contact_force,
    input wire logic        detached
);

    `ESPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pos_x))
    `ESPC_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready)
    `ESPC_ASSERT_NOW(a_detach_zero, out_valid && detached, contact_force == '0)
    `ESPC_ASSERT_NOW(a_contact_raw, out_valid && !detached, {1'b0, contact_force} == raw_force)

endmodule

bind euler_step_particle_on_circle espc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .pos_x         (out_ch.pos_x),
    .raw_force     (out_ch.raw_force),
    .contact_force (out_ch.contact_force),
    .detached      (out_ch.detached)
);
`default_nettype wire
